/* rtl/tfc_pkg.sv */
// shared types and constants for the temperature frame crc16 unit
package tfc_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int TEMP_W      = 13;
  localparam int CRC_W       = 16;
  localparam int CODE_W      = 16;
  localparam int PREFIX_W    = 32;
  localparam int STEPS_CFG_W = 5;
  localparam int PBYTES_W    = 3;

  // shift steps one cell can apply
  localparam int CELL_STEPS = 8;
  localparam int STEP_W     = $clog2(CELL_STEPS + 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_CRC_SEED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRC_POLY   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRC_MASK   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEPS      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PREFIX     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_PREFIX_CNT = 3'd5;

  localparam logic [CRC_W-1:0]       RST_CRC_SEED   = 16'hFFFF;
  localparam logic [CRC_W-1:0]       RST_CRC_POLY   = 16'hA001;
  localparam logic [CRC_W-1:0]       RST_CRC_MASK   = 16'h0001;
  localparam logic [STEPS_CFG_W-1:0] RST_STEPS      = 5'd8;
  localparam logic [PREFIX_W-1:0]    RST_PREFIX     = 32'h0;
  localparam logic [PBYTES_W-1:0]    RST_PREFIX_CNT = 3'd4;

  typedef enum logic [1:0] {
    SRC_CFG,
    SRC_CODE_HI,
    SRC_CODE_LO
  } tfc_src_t;

  typedef struct packed {
    logic [CRC_W-1:0]  crc;
    logic [CODE_W-1:0] code;
  } tfc_tok_t;

  typedef struct packed {
    tfc_src_t          src;
    logic              xor_en;
    logic [7:0]        cfg_byte;
    logic [STEP_W-1:0] nsteps;
  } tfc_ctl_t;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] mask;
  } tfc_crc_cfg_t;

endpackage

/* rtl/tfc_scale.sv */
// entry stage: scales the temperature by ten and loads the crc start value
module tfc_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [tfc_pkg::TEMP_W-1:0] temperature,
  input  logic [tfc_pkg::CRC_W-1:0]  crc_seed,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output tfc_pkg::tfc_tok_t          dn_tok
);
  import tfc_pkg::*;

  logic              valid_r;
  tfc_tok_t          tok_r;
  logic [CODE_W-1:0] ext;
  tfc_tok_t          tok_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    ext          = {{(CODE_W - TEMP_W){temperature[TEMP_W-1]}}, temperature};
    tok_nxt.code = (ext << 3) + (ext << 1);
    tok_nxt.crc  = crc_seed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

/* rtl/tfc_cell.sv */
// crc cell: optional byte xor followed by up to eight shift steps, one register stage
module tfc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  tfc_pkg::tfc_tok_t     up_tok,
  input  tfc_pkg::tfc_ctl_t     ctl,
  input  tfc_pkg::tfc_crc_cfg_t crc_cfg,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output tfc_pkg::tfc_tok_t     dn_tok
);
  import tfc_pkg::*;

  logic             valid_r;
  tfc_tok_t         tok_r;
  tfc_tok_t         tok_nxt;
  logic [7:0]       sel_byte;
  logic [CRC_W-1:0] crc_v;
  logic             hit;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    case (ctl.src)
      SRC_CFG:     sel_byte = ctl.cfg_byte;
      SRC_CODE_HI: sel_byte = up_tok.code[15:8];
      SRC_CODE_LO: sel_byte = up_tok.code[7:0];
      default:     sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    crc_v = up_tok.crc ^ (ctl.xor_en ? {8'h00, sel_byte} : {CRC_W{1'b0}});
    hit   = 1'b0;
    for (int k = 0; k < CELL_STEPS; k++) begin
      if (STEP_W'(k) < ctl.nsteps) begin
        hit   = |(crc_v & crc_cfg.mask);
        crc_v = {1'b0, crc_v[CRC_W-1:1]} ^ (hit ? crc_cfg.poly : {CRC_W{1'b0}});
      end
    end
    tok_nxt.crc  = crc_v;
    tok_nxt.code = up_tok.code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

/* rtl/temperature_frame_crc16_unit.sv */
// top level: temperature scaling and configurable crc16 frame builder
//
//   port group  dir  payload
//   in_*        in   tdata[12:0] temperature (signed)
//   out_*       out  tdata[15:0] scaled_code, [31:16] crc_swapped, [95:32] frame_word
//   cfg_*       in   register index and write data, no read-back
//
// one word per cycle sustained while out_tready stays high; the pipeline has one scaling stage
// and (MAX_PREFIX_BYTES + 2) * ceil(MAX_STEPS / 8) crc cells, each cell doing at most 8 steps
// every stage holds its word under back-pressure and takes a new one when it drains
// synchronous active-low reset clears all valid flags and loads register defaults
module temperature_frame_crc16_unit #(
  parameter int MAX_PREFIX_BYTES = 4,
  parameter int MAX_STEPS        = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tfc_pkg::IN_TDATA_W-1:0]   in_tdata,   // temperature
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tfc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // scaled_code, crc_swapped, frame_word
  input  logic                             cfg_wr_en,
  input  logic [tfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tfc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tfc_pkg::*;

  localparam int CPB    = (MAX_STEPS + CELL_STEPS - 1) / CELL_STEPS;
  localparam int NSLOTS = MAX_PREFIX_BYTES + 2;
  localparam int NCELLS = NSLOTS * CPB;

  logic [CRC_W-1:0]       crc_seed_r;
  logic [CRC_W-1:0]       crc_poly_r;
  logic [CRC_W-1:0]       crc_mask_r;
  logic [STEPS_CFG_W-1:0] steps_r;
  logic [PREFIX_W-1:0]    prefix_r;
  logic [PBYTES_W-1:0]    pbytes_r;

  logic [STEPS_CFG_W-1:0] steps_eff;
  logic [PBYTES_W-1:0]    pbytes_eff;
  tfc_crc_cfg_t           crc_cfg;

  logic                   vld   [NCELLS+1];
  logic                   rdy   [NCELLS+1];
  tfc_tok_t               tok   [NCELLS+1];

  logic [CRC_W-1:0]       crc_swapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r <= RST_CRC_SEED;
      crc_poly_r <= RST_CRC_POLY;
      crc_mask_r <= RST_CRC_MASK;
      steps_r    <= RST_STEPS;
      prefix_r   <= RST_PREFIX;
      pbytes_r   <= RST_PREFIX_CNT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_CRC_SEED:   crc_seed_r <= cfg_wdata[CRC_W-1:0];
        CFG_CRC_POLY:   crc_poly_r <= cfg_wdata[CRC_W-1:0];
        CFG_CRC_MASK:   crc_mask_r <= cfg_wdata[CRC_W-1:0];
        CFG_STEPS:      steps_r    <= cfg_wdata[STEPS_CFG_W-1:0];
        CFG_PREFIX:     prefix_r   <= cfg_wdata[PREFIX_W-1:0];
        CFG_PREFIX_CNT: pbytes_r   <= cfg_wdata[PBYTES_W-1:0];
        default:        ;
      endcase
    end
  end

  assign steps_eff  = (steps_r > STEPS_CFG_W'(MAX_STEPS)) ? STEPS_CFG_W'(MAX_STEPS) : steps_r;
  assign pbytes_eff = (pbytes_r > PBYTES_W'(MAX_PREFIX_BYTES)) ?
                      PBYTES_W'(MAX_PREFIX_BYTES) : pbytes_r;

  assign crc_cfg.poly = crc_poly_r;
  assign crc_cfg.mask = crc_mask_r;

  tfc_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_tvalid),
    .up_ready    (in_tready),
    .temperature (in_tdata[TEMP_W-1:0]),
    .crc_seed    (crc_seed_r),
    .dn_valid    (vld[0]),
    .dn_ready    (rdy[0]),
    .dn_tok      (tok[0])
  );

  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    localparam int SLOT = c / CPB;
    localparam int SUB  = c % CPB;
    localparam int BASE = SUB * CELL_STEPS;

    logic [STEPS_CFG_W-1:0] rem;
    logic                   slot_en;
    tfc_src_t               src;
    logic [7:0]             cfg_byte;
    tfc_ctl_t               ctl;

    if (SLOT < MAX_PREFIX_BYTES) begin : g_prefix
      // prefix slots run from the highest byte index down
      localparam int K = MAX_PREFIX_BYTES - 1 - SLOT;
      assign slot_en  = PBYTES_W'(K) < pbytes_eff;
      assign src      = SRC_CFG;
      assign cfg_byte = prefix_r[8*K +: 8];
    end else if (SLOT == MAX_PREFIX_BYTES) begin : g_code_hi
      assign slot_en  = 1'b1;
      assign src      = SRC_CODE_HI;
      assign cfg_byte = 8'h00;
    end else begin : g_code_lo
      assign slot_en  = 1'b1;
      assign src      = SRC_CODE_LO;
      assign cfg_byte = 8'h00;
    end

    always_comb begin
      rem          = steps_eff - STEPS_CFG_W'(BASE);
      ctl.src      = src;
      ctl.cfg_byte = cfg_byte;
      ctl.xor_en   = slot_en && (SUB == 0);
      if (!slot_en || steps_eff <= STEPS_CFG_W'(BASE)) begin
        ctl.nsteps = '0;
      end else if (rem >= STEPS_CFG_W'(CELL_STEPS)) begin
        ctl.nsteps = STEP_W'(CELL_STEPS);
      end else begin
        ctl.nsteps = rem[STEP_W-1:0];
      end
    end

    tfc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[c]),
      .up_ready (rdy[c]),
      .up_tok   (tok[c]),
      .ctl      (ctl),
      .crc_cfg  (crc_cfg),
      .dn_valid (vld[c+1]),
      .dn_ready (rdy[c+1]),
      .dn_tok   (tok[c+1])
    );
  end

  assign rdy[NCELLS] = out_tready;
  assign out_tvalid  = vld[NCELLS];
  assign crc_swapped = {tok[NCELLS].crc[7:0], tok[NCELLS].crc[15:8]};
  assign out_tdata   = {prefix_r, tok[NCELLS].code, crc_swapped, crc_swapped, tok[NCELLS].code};

endmodule

/* rtl/tfc_check.sv */
// port-level checks for the temperature frame crc16 unit, bound to the top level
module tfc_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tfc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tfc_pkg::*;

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // frame carries the same code and crc as the separate fields
  a_frame_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:48] == out_tdata[15:0]) &&
                   (out_tdata[47:32] == out_tdata[31:16]))
    else $error("frame fields disagree with code or crc");

  // a drained or idle output side never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready || !out_tvalid |-> in_tready)
    else $error("input stalled with a free output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind temperature_frame_crc16_unit tfc_check u_tfc_check (.*);

/* test/temperature_frame_crc16_unit_tb.sv */
// testbench for the temperature frame crc16 unit: predicted frames checked against the stream output
module temperature_frame_crc16_unit_tb;
  import tfc_pkg::*;

  localparam int MAX_PREFIX_BYTES = 4;
  localparam int MAX_STEPS        = 16;
  localparam int CLK_HALF         = 6;
  localparam int PIPE_LATENCY     = 1 + (MAX_PREFIX_BYTES + 2) * ((MAX_STEPS + 7) / 8);
  localparam int DRAIN_LIMIT      = 5000;
  localparam int RUN_LIMIT_CYCLES = 400000;
  localparam int TEMP_LO          = -3276;
  localparam int TEMP_HI          = 3276;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0] scaled_code;
    logic [CRC_W-1:0]  crc_swapped;
    logic [63:0]       frame_word;
  } frame_result_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // temperature
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;         // scaled_code, crc_swapped, frame_word
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;

  logic [CRC_W-1:0]       crc_seed_sh    = RST_CRC_SEED;
  logic [CRC_W-1:0]       crc_poly_sh    = RST_CRC_POLY;
  logic [CRC_W-1:0]       crc_mask_sh    = RST_CRC_MASK;
  logic [STEPS_CFG_W-1:0] steps_sh       = RST_STEPS;
  logic [PREFIX_W-1:0]    prefix_sh      = RST_PREFIX;
  logic [PBYTES_W-1:0]    prefix_cnt_sh  = RST_PREFIX_CNT;

  frame_result_t expected_frames[$];
  int  fail_count    = 0;
  bit  tx_idle       = 1'b1;
  bit  rx_idle       = 1'b1;
  int  stall_request = 0;

  temperature_frame_crc16_unit #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES),
    .MAX_STEPS       (MAX_STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [CRC_W-1:0] crc_feed_byte(logic [CRC_W-1:0] crc, logic [7:0] b,
                                                     int nsteps);
    int   s;
    logic hit;
    crc = crc ^ {8'h00, b};
    for (s = 0; s < nsteps; s++) begin
      hit = |(crc & crc_mask_sh);
      crc = crc >> 1;
      if (hit) begin
        crc = crc ^ crc_poly_sh;
      end
    end
    return crc;
  endfunction

  function automatic frame_result_t predict_frame(logic [TEMP_W-1:0] temp);
    frame_result_t    r;
    logic [CRC_W-1:0] crc;
    int               reading;
    int               nsteps;
    int               nbytes;
    int               i;
    reading = $signed(temp);
    r.scaled_code = 16'(reading * 10);
    nsteps = (steps_sh > MAX_STEPS) ? MAX_STEPS : steps_sh;
    nbytes = (prefix_cnt_sh > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : prefix_cnt_sh;
    crc = crc_seed_sh;
    for (i = nbytes; i > 0; i--) begin
      crc = crc_feed_byte(crc, prefix_sh[(i-1)*8 +: 8], nsteps);
    end
    crc = crc_feed_byte(crc, r.scaled_code[15:8], nsteps);
    crc = crc_feed_byte(crc, r.scaled_code[7:0], nsteps);
    r.crc_swapped = {crc[7:0], crc[15:8]};
    r.frame_word  = {prefix_sh, r.scaled_code, r.crc_swapped};
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_reg_value(logic [CFG_ADDR_W-1:0] addr);
    logic [CFG_DATA_W-1:0] junk;
    int                    pick;
    junk = $urandom;
    pick = $urandom_range(0, 3);
    case (addr)
      CFG_CRC_SEED, CFG_CRC_POLY, CFG_CRC_MASK: begin
        if (pick == 0) junk[15:0] = 16'h0000;
        else if (pick == 1) junk[15:0] = 16'hFFFF;
      end
      CFG_STEPS: begin
        if (pick == 0) junk[4:0] = 5'd0;
        else if (pick == 1) junk[4:0] = 5'd31;
        else junk[4:0] = 5'($urandom_range(1, MAX_STEPS));
      end
      CFG_PREFIX_CNT: begin
        if (pick == 0) junk[2:0] = 3'd0;
        else if (pick == 1) junk[2:0] = 3'd7;
        else junk[2:0] = 3'($urandom_range(1, MAX_PREFIX_BYTES));
      end
      default: begin
        if (pick == 0) junk = '0;
        else if (pick == 1) junk = '1;
      end
    endcase
    return junk;
  endfunction

  function automatic int random_reading();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(0, (1 << TEMP_W) - 1);
    end
    return int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
  endfunction

  task automatic apply_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_CRC_SEED:   crc_seed_sh   = data[CRC_W-1:0];
      CFG_CRC_POLY:   crc_poly_sh   = data[CRC_W-1:0];
      CFG_CRC_MASK:   crc_mask_sh   = data[CRC_W-1:0];
      CFG_STEPS:      steps_sh      = data[STEPS_CFG_W-1:0];
      CFG_PREFIX:     prefix_sh     = data[PREFIX_W-1:0];
      CFG_PREFIX_CNT: prefix_cnt_sh = data[PBYTES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_reg(addr, data);
    @(posedge clk);
  endtask

  task automatic send_reading(input int temp);
    int                gap;
    logic [TEMP_W-1:0] t;
    t = temp[TEMP_W-1:0];
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-TEMP_W){1'b0}}, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_frames.push_back(predict_frame(t));
  endtask

  task automatic wait_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_frames.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_default_frames();
    send_reading(0);
    send_reading(1);
    send_reading(-1);
    send_reading(TEMP_HI);
    send_reading(TEMP_LO);
    send_reading(4095);
    send_reading(-4096);
    send_reading(13'h0AAA);
    send_reading(13'h1555);
    wait_results();
  endtask

  task automatic test_register_extremes();
    // no shifting, no prefix, all-ones mask and polynomial
    write_reg(CFG_CRC_SEED, 32'h0000_0000);
    write_reg(CFG_CRC_POLY, 32'hFFFF_FFFF);
    write_reg(CFG_CRC_MASK, 32'h0000_FFFF);
    write_reg(CFG_STEPS, 32'h0000_0000);
    write_reg(CFG_PREFIX, 32'hFFFF_FFFF);
    write_reg(CFG_PREFIX_CNT, 32'h0000_0000);
    send_reading(-4096);
    send_reading(4095);
    send_reading(0);
    wait_results();
    // full step count, full prefix, polynomial never applied
    write_reg(CFG_STEPS, 32'd16);
    write_reg(CFG_PREFIX_CNT, 32'd4);
    write_reg(CFG_CRC_MASK, 32'h0000_0000);
    send_reading(TEMP_HI);
    send_reading(TEMP_LO);
    send_reading(-1);
    wait_results();
    // counts above their limits get clamped
    write_reg(CFG_STEPS, 32'd31);
    write_reg(CFG_PREFIX_CNT, 32'd7);
    write_reg(CFG_CRC_SEED, 32'h0000_FFFF);
    write_reg(CFG_CRC_POLY, 32'h0000_0000);
    write_reg(CFG_CRC_MASK, 32'h0000_8000);
    send_reading(1);
    send_reading(13'h0AAA);
    send_reading(13'h1555);
    wait_results();
    // spare indexes ignored, junk above register widths dropped
    write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    write_reg(CFG_CRC_POLY, 32'hFFFF_A001);
    write_reg(CFG_CRC_MASK, 32'hFFFF_0001);
    write_reg(CFG_STEPS, 32'hFFFF_FFE1);
    write_reg(CFG_PREFIX_CNT, 32'hFFFF_FFF9);
    write_reg(CFG_PREFIX, 32'h1234_5678);
    send_reading(100);
    send_reading(-100);
    send_reading(2048);
    wait_results();
  endtask

  task automatic test_output_stall_fill();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    stall_request = 80;
    repeat (40) send_reading(random_reading());
    wait_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int                    phase;
    int                    n;
    int                    idx;
    int                    pause_at;
    logic [CFG_ADDR_W-1:0] addr;
    for (phase = 0; phase < 10; phase++) begin
      for (idx = 0; idx < (1 << CFG_ADDR_W); idx++) begin
        addr = idx[CFG_ADDR_W-1:0];
        if ((addr >= CFG_SPARE_LO) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 3) != 0)) begin
          write_reg(addr, random_reg_value(addr));
        end
      end
      tx_idle  = ($urandom_range(0, 3) != 0);
      rx_idle  = ($urandom_range(0, 3) != 0);
      pause_at = $urandom_range(5, 45);
      for (n = 0; n < 50; n++) begin
        send_reading(random_reading());
        if (n == pause_at) begin
          wait_results();
        end
      end
      wait_results();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      hold = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    frame_result_t exp_frame;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected word on output: %h", out_tdata);
        fail_count++;
      end else begin
        exp_frame = expected_frames.pop_front();
        if (out_tdata[15:0] !== exp_frame.scaled_code) begin
          $error("scaled_code expected %h actual %h", exp_frame.scaled_code, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[31:16] !== exp_frame.crc_swapped) begin
          $error("crc_swapped expected %h actual %h", exp_frame.crc_swapped, out_tdata[31:16]);
          fail_count++;
        end
        if (out_tdata[95:32] !== exp_frame.frame_word) begin
          $error("frame_word expected %h actual %h", exp_frame.frame_word, out_tdata[95:32]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_frames();
    test_register_extremes();
    test_output_stall_fill();
    test_random_frames();
    if (expected_frames.size() != 0) begin
      $error("%0d expected words never arrived", expected_frames.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * RUN_LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule
